// ===== rtl/core/olad_pkg.sv =====
// Shared codes, field widths and types for the ordered list block.
`timescale 1ns / 1ps

package olad_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_LIST   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

endpackage

// ===== rtl/core/olad_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module olad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/ordered_list_append_delete_at.sv =====
// Top level: ordered list of signed values with append, delete by position and listing.
`timescale 1ns / 1ps

// Keeps up to DEPTH signed 32-bit values in insertion order in one RAM.
// s_tuser selects the operation: append at the tail, delete at a 1-based
// position, or list all entries. Append and the error cases of delete give one
// result each. Delete at position p of a list of n entries moves the n-p later
// entries forward through the RAM, one read and one write per cycle, and then
// gives one result. Listing streams one entry per cycle from the RAM read port
// while m_tready keeps the output register free, with tlast on the final one; an
// empty list gives a single result with status "list empty". Input is taken
// only while no operation is in progress and the output register is free or
// being emptied. No clearing pass is needed after reset.
module ordered_list_append_delete_at
    import olad_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // value[31:0], position[37:32], zero[39:38]
    input  logic [1:0]          s_tuser,   // mode[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // status[1:0], entry_value[33:2], zero[39:34]
    output logic                m_tuser,   // entry_valid
    output logic                m_tlast    // last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = CW + 1;
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_LIST
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic                 m_valid_reg, m_valid_next;
    status_t              status_reg, status_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic                 ev_reg, ev_next;
    logic                 last_reg, last_next;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [VALUE_W-1:0]   wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [VALUE_W-1:0]   rd_data;

    logic                 s_accept;
    logic                 out_free;
    logic [VALUE_W-1:0]   in_value;
    logic [POS_W-1:0]     in_pos;
    logic [PW-1:0]        pos_w;
    logic [PW-1:0]        cnt_w;
    logic                 list_last;

    assign in_value  = s_tdata[VALUE_W-1:0];
    assign in_pos    = s_tdata[VALUE_W+POS_W-1:VALUE_W];
    assign pos_w     = PW'(in_pos);
    assign cnt_w     = PW'(count_reg);
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign list_last = (IW'(idx_reg) + IW'(1)) == IW'(count_reg);

    olad_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        value_next   = value_reg;
        ev_next      = ev_reg;
        last_next    = last_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = rd_data;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    // single result by default; listing overrides below
                    value_next = '0;
                    ev_next    = 1'b0;
                    last_next  = 1'b1;
                    unique case (mode_t'(s_tuser))
                        MODE_APPEND:
                        begin
                            m_valid_next = 1'b1;
                            if (count_reg >= CW'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = count_reg[AW-1:0];
                                wr_data     = in_value;
                                count_next  = count_reg + CW'(1);
                                status_next = STAT_OK;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                m_valid_next = 1'b1;
                                status_next  = STAT_EMPTY;
                            end
                            else if (pos_w == '0 || pos_w > cnt_w)
                            begin
                                m_valid_next = 1'b1;
                                status_next  = STAT_RANGE;
                            end
                            else if (pos_w < cnt_w)
                            begin
                                idx_next   = AW'(pos_w - PW'(1));
                                rd_en      = 1'b1;
                                rd_addr    = in_pos[AW-1:0];
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                count_next   = count_reg - CW'(1);
                                m_valid_next = 1'b1;
                                status_next  = STAT_OK;
                            end
                        end
                        MODE_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                m_valid_next = 1'b1;
                                status_next  = STAT_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                // rd_data holds entry idx+1
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                if ((IW'(idx_reg) + IW'(2)) < IW'(count_reg))
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(IW'(idx_reg) + IW'(2));
                    idx_next = AW'(IW'(idx_reg) + IW'(1));
                end
                else
                begin
                    count_next   = count_reg - CW'(1);
                    m_valid_next = 1'b1;
                    status_next  = STAT_OK;
                    value_next   = '0;
                    ev_next      = 1'b0;
                    last_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_LIST:
            begin
                // rd_data holds entry idx
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    status_next  = STAT_OK;
                    value_next   = rd_data;
                    ev_next      = 1'b1;
                    last_next    = list_last;
                    if (list_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(IW'(idx_reg) + IW'(1));
                        idx_next = AW'(IW'(idx_reg) + IW'(1));
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        ev_reg     <= ev_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - VALUE_W - 2){1'b0}}, value_reg, status_reg};
    assign m_tuser  = ev_reg;
    assign m_tlast  = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("list count above depth");

    a_shift_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> !m_valid_reg)
        else $error("result pending while entries are being moved");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_SHIFT ||
                   (s_accept && mode_t'(s_tuser) == MODE_APPEND)))
        else $error("RAM write outside append or delete");

    a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST && out_free && list_last) |=>
            (state_reg == S_IDLE && m_valid_reg && last_reg && ev_reg))
        else $error("final listed entry not flagged");

endmodule
